### sv/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Command and response payloads, configuration set, cell memory request and
// the sequencer state encoding.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Cell store geometry (cell memory is MAX_COLS x MAX_ROWS cells)
  localparam int          ADDR_W      = 12;
  localparam int          STORE_DEPTH = 4096;
  localparam logic [7:0]  MAX_COLS    = 8'd128;
  localparam logic [5:0]  MAX_ROWS    = 6'd32;

  // Character codes
  localparam logic [7:0]  CODE_NEWLINE = 8'd10;
  localparam logic [7:0]  CODE_BLANK   = 8'd32;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORE_COLOR    = 3'd0,
    CFG_BACK_COLOR    = 3'd1,
    CFG_SCREEN_WIDTH  = 3'd2,
    CFG_SCREEN_HEIGHT = 3'd3,
    CFG_FIRST_COL     = 3'd4,
    CFG_FIRST_ROW     = 3'd5
  } cfg_idx_t;

  // Command kinds
  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_code;
    logic [4:0] cell_row;
    logic [6:0] cell_col;
  } cmd_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [7:0] cursor_col;
    logic [7:0] read_char;
    logic [7:0] read_attr;
  } rsp_t;

  typedef struct packed {
    logic [3:0] fore_color;
    logic [3:0] back_color;
    logic [7:0] screen_width;
    logic [5:0] screen_height;
    logic [6:0] first_col;
    logic [4:0] first_row;
  } cfg_t;

  // One write port and one read port into the cell memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCROLL,
    S_BLANK_BASE,
    S_BLANK,
    S_PUT,
    S_READ,
    S_READ_WAIT,
    S_DONE
  } seq_state_t;

endpackage
`default_nettype wire

### sv/text_console_writer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer_core: text-mode console engine
// Character cell memory with cursor, scroll, region clear, line blanking and
// cell read-back.
//
//   channel   ports                        transfer
//   command   start, busy, cmd             start high while busy low
//   result    done, rsp                    done high, one cycle, no stall
//   config    cfg_we, cfg_index, cfg_data  cfg_we high, any cycle
//
// The engine stays busy from the accepting edge until done; it then returns
// to idle, where the next command can be accepted. A scroll copies one cell
// per cycle through the memory read/write ports, then blanks the bottom row
// when first_col lies within the width, and a pending put follows. Clear and
// line blanking write one cell per cycle after a row base setup state. Reset
// returns the cursor to the origin and the registers to their defaults; cell
// memory contents stay undefined until written. Results cannot be stalled.
// ----------------------------------------------------------------------------
module text_console_writer_core import tcw_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire cmd_t                  cmd,
  output logic                       done,
  output rsp_t                       rsp,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t        cfg;
  mem_req_t    mem_req;
  logic [15:0] mem_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fore_color    <= 4'd15;
      cfg.back_color    <= 4'd0;
      cfg.screen_width  <= 8'd80;
      cfg.screen_height <= 6'd25;
      cfg.first_col     <= 7'd0;
      cfg.first_row     <= 5'd0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FORE_COLOR:    cfg.fore_color    <= cfg_data[3:0];
        CFG_BACK_COLOR:    cfg.back_color    <= cfg_data[3:0];
        CFG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[7:0];
        CFG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[5:0];
        CFG_FIRST_COL:     cfg.first_col     <= cfg_data[6:0];
        CFG_FIRST_ROW:     cfg.first_row     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // command sequencer
  tcw_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .rsp       (rsp),
    .cfg       (cfg),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // cell memory
  tcw_cell_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

### sv/tcw_cell_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_cell_ram: character cell memory
// Simple dual-port synchronous RAM, one write and one registered read per
// cycle. Each word holds {attribute, character}.
// ----------------------------------------------------------------------------
module tcw_cell_ram import tcw_pkg::*; (
  input  wire logic        clk,
  input  wire mem_req_t    req,
  output logic [15:0]      rdata
);

  logic [15:0] mem [STORE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule
`default_nettype wire

### sv/tcw_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_seq: command sequencer of the text console writer
// Holds the cursor and walks the cell memory for put, scroll, blanking and
// read. One shared width multiplier forms row base addresses and the scroll end.
// ----------------------------------------------------------------------------
module tcw_seq import tcw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire cmd_t        cmd,
  output logic             done,
  output rsp_t             rsp,
  input  wire cfg_t        cfg,
  output mem_req_t         mem_req,
  input  wire logic [15:0] mem_rdata
);

  seq_state_t state, state_next;

  cmd_t              cmd_q;
  logic [4:0]        cur_row;
  logic [7:0]        cur_col;
  logic [7:0]        rd_char;
  logic [7:0]        rd_attr;
  logic [12:0]       cnt;
  logic [12:0]       scroll_end;
  logic              scroll_vld;
  logic [ADDR_W-1:0] scroll_src;
  logic [4:0]        blk_row;
  logic [4:0]        blk_last;
  logic [6:0]        blk_col;
  logic [ADDR_W-1:0] row_base;

  logic [7:0]        eff_w;
  logic [5:0]        eff_h;
  logic [5:0]        h_last;
  logic              blank_ok;
  logic              put_pending;
  logic              need_nl;
  logic              row_adv;
  logic              blk_col_last;
  logic              cnt_run;
  logic [5:0]        mul_b;
  logic [13:0]       mul_p;
  logic [ADDR_W-1:0] put_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        attr;
  seq_state_t        post_state;

  // effective geometry and common conditions
  always_comb begin
    if (cfg.screen_width == 8'd0) begin
      eff_w = 8'd1;
    end else if (cfg.screen_width > MAX_COLS) begin
      eff_w = MAX_COLS;
    end else begin
      eff_w = cfg.screen_width;
    end
    if (cfg.screen_height == 6'd0) begin
      eff_h = 6'd1;
    end else if (cfg.screen_height > MAX_ROWS) begin
      eff_h = MAX_ROWS;
    end else begin
      eff_h = cfg.screen_height;
    end
  end

  assign h_last       = eff_h - 6'd1;
  assign blank_ok     = {1'b0, cfg.first_col} < eff_w;
  assign put_pending  = (cmd_q.kind == KIND_PUT) && (cmd_q.char_code != CODE_NEWLINE);
  assign need_nl      = (cmd_q.char_code == CODE_NEWLINE) || (cur_col >= eff_w);
  assign row_adv      = {1'b0, cur_row} < h_last;
  assign blk_col_last = {1'b0, blk_col} == (eff_w - 8'd1);
  assign cnt_run      = cnt < scroll_end;
  assign attr         = {cfg.back_color, cfg.fore_color};
  assign post_state   = put_pending ? S_PUT : S_DONE;

  // shared multiplier: width times a row count
  always_comb begin
    case (state)
      S_DISPATCH:   mul_b = eff_h;
      S_BLANK_BASE: mul_b = {1'b0, blk_row};
      S_PUT:        mul_b = {1'b0, cur_row};
      S_READ:       mul_b = {1'b0, cmd_q.cell_row};
      default:      mul_b = '0;
    endcase
  end

  assign mul_p    = {6'd0, eff_w} * {8'd0, mul_b};
  assign put_addr = mul_p[ADDR_W-1:0] + {4'd0, cur_col};
  assign rd_addr  = mul_p[ADDR_W-1:0] + {5'd0, cmd_q.cell_col};

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory requests
  always_comb begin
    state_next = state;
    mem_req    = '0;

    // scroll copy write lands in the cycle after its read
    if (scroll_vld) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = scroll_src - {4'd0, eff_w};
      mem_req.wdata = mem_rdata;
    end

    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (cmd_q.kind)
          KIND_PUT: begin
            if (need_nl) begin
              state_next = row_adv ? post_state : S_SCROLL;
            end else begin
              state_next = S_PUT;
            end
          end
          KIND_CLEAR: begin
            if (({1'b0, cfg.first_row} < eff_h) && blank_ok) begin
              state_next = S_BLANK_BASE;
            end else begin
              state_next = S_DONE;
            end
          end
          KIND_LINE: begin
            if ((cur_col != 8'd0) && blank_ok) begin
              state_next = S_BLANK_BASE;
            end else begin
              state_next = S_DONE;
            end
          end
          default: state_next = S_READ;
        endcase
      end
      S_SCROLL: begin
        if (cnt_run) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = cnt[ADDR_W-1:0];
        end else begin
          state_next = blank_ok ? S_BLANK_BASE : post_state;
        end
      end
      S_BLANK_BASE: state_next = S_BLANK;
      S_BLANK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = row_base + {5'd0, blk_col};
        mem_req.wdata = {attr, CODE_BLANK};
        if (blk_col_last && (blk_row == blk_last)) begin
          state_next = post_state;
        end
      end
      S_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = put_addr;
        mem_req.wdata = {attr, cmd_q.char_code};
        state_next    = S_DONE;
      end
      S_READ: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = rd_addr;
        state_next    = S_READ_WAIT;
      end
      S_READ_WAIT: state_next = S_DONE;
      S_DONE:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // cursor and scroll pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row    <= '0;
      cur_col    <= '0;
      scroll_vld <= 1'b0;
    end else begin
      scroll_vld <= (state == S_SCROLL) && cnt_run;
      case (state)
        S_DISPATCH: begin
          if (cmd_q.kind == KIND_PUT && need_nl) begin
            cur_col <= '0;
            if (row_adv) begin
              cur_row <= cur_row + 5'd1;
            end
          end else if (cmd_q.kind == KIND_LINE) begin
            cur_col <= '0;
          end
        end
        S_PUT:   cur_col <= cur_col + 8'd1;
        default: ;
      endcase
    end
  end

  // sweep counters and result payload
  always_ff @(posedge clk) begin
    scroll_src <= cnt[ADDR_W-1:0];
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd_q   <= cmd;
          rd_char <= '0;
          rd_attr <= '0;
        end
      end
      S_DISPATCH: begin
        scroll_end <= mul_p[12:0];
        cnt        <= {5'd0, eff_w};
        case (cmd_q.kind)
          KIND_CLEAR: begin
            blk_row  <= cfg.first_row;
            blk_last <= h_last[4:0];
          end
          KIND_LINE: begin
            blk_row  <= cur_row;
            blk_last <= cur_row;
          end
          default: begin
            blk_row  <= h_last[4:0];
            blk_last <= h_last[4:0];
          end
        endcase
      end
      S_SCROLL: begin
        if (cnt_run) begin
          cnt <= cnt + 13'd1;
        end
      end
      S_BLANK_BASE: begin
        row_base <= mul_p[ADDR_W-1:0];
        blk_col  <= cfg.first_col;
      end
      S_BLANK: begin
        if (blk_col_last) begin
          blk_col  <= cfg.first_col;
          blk_row  <= blk_row + 5'd1;
          row_base <= row_base + {4'd0, eff_w};
        end else begin
          blk_col <= blk_col + 7'd1;
        end
      end
      S_READ_WAIT: begin
        rd_char <= mem_rdata[7:0];
        rd_attr <= mem_rdata[15:8];
      end
      default: ;
    endcase
  end

  // handshake and result
  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  always_comb begin
    rsp.cursor_row = cur_row;
    rsp.cursor_col = cur_col;
    rsp.read_char  = rd_char;
    rsp.read_attr  = rd_attr;
  end

endmodule
`default_nettype wire

### bench/text_console_writer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_core_tb: self-checking bench for the console engine
// Commands are queued by a stimulus process and sent by a clocked driver. A
// clocked monitor runs a shadow console on every accepted command and checks
// each result against the oldest prediction. The register set is changed
// between phases while the engine is idle, from extreme and random settings.
// ----------------------------------------------------------------------------
module text_console_writer_core_tb;
  import tcw_pkg::*;

  localparam int QUIET_LIMIT = 40000;

  typedef struct {
    cmd_t cmd;
    bit   drain;
  } cmd_slot_t;

  // DUT ports
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  start     = 1'b0;
  logic                  busy;
  cmd_t                  cmd_bus   = '0;
  logic                  done;
  rsp_t                  rsp;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Stimulus and bookkeeping
  cmd_slot_t cmd_backlog[$];
  cmd_slot_t next_slot;
  rsp_t      pending_replies[$];
  int        n_issued     = 0;
  int        n_accepted   = 0;
  int        n_compared   = 0;
  int        n_cfg_writes = 0;
  int        mismatches   = 0;
  int        scroll_count = 0;
  int        quiet_cycles = 0;
  int        kind_count[4];
  bit        steady_run   = 1'b0;

  // Shadow console
  logic [15:0] shadow_cells [STORE_DEPTH];
  cfg_t        shadow_cfg;
  int          cursor_r;
  int          cursor_c;

  text_console_writer_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd_bus),
    .done      (done),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow console
  // ---------------------------------------------------------------------------

  // Width and height as the engine uses them: zero acts as one, clamp at max
  function automatic int span_cols();
    if (shadow_cfg.screen_width == 0) return 1;
    if (shadow_cfg.screen_width > MAX_COLS) return int'(MAX_COLS);
    return int'(shadow_cfg.screen_width);
  endfunction

  function automatic int span_rows();
    if (shadow_cfg.screen_height == 0) return 1;
    if (shadow_cfg.screen_height > MAX_ROWS) return int'(MAX_ROWS);
    return int'(shadow_cfg.screen_height);
  endfunction

  // Row stride is the active width; addresses wrap over the store
  function automatic int cell_index(int row, int col);
    return (col + span_cols() * row) % STORE_DEPTH;
  endfunction

  function automatic logic [7:0] attr_byte();
    return {shadow_cfg.back_color, shadow_cfg.fore_color};
  endfunction

  function automatic void blank_row(int row);
    int w;
    w = span_cols();
    for (int col = int'(shadow_cfg.first_col); col < w; col++)
      shadow_cells[cell_index(row, col)] = {attr_byte(), CODE_BLANK};
  endfunction

  // Down one row, or scroll when at (or below) the last row
  function automatic void next_line();
    int w;
    int h;
    w = span_cols();
    h = span_rows();
    cursor_c = 0;
    if (cursor_r < h - 1) begin
      cursor_r++;
    end else begin
      for (int row = 1; row < h; row++)
        for (int col = 0; col < w; col++)
          shadow_cells[cell_index(row - 1, col)] = shadow_cells[cell_index(row, col)];
      blank_row(h - 1);
      scroll_count++;
    end
  endfunction

  function automatic rsp_t console_step(cmd_t c);
    rsp_t        r;
    logic [15:0] cell_word;
    r = '0;
    case (c.kind)
      KIND_PUT: begin
        if (c.char_code == CODE_NEWLINE) begin
          next_line();
        end else begin
          if (cursor_c > span_cols() - 1) next_line();
          shadow_cells[cell_index(cursor_r, cursor_c)] = {attr_byte(), c.char_code};
          cursor_c++;
        end
      end
      KIND_CLEAR: begin
        for (int row = int'(shadow_cfg.first_row); row < span_rows(); row++) blank_row(row);
      end
      KIND_LINE: begin
        if (cursor_c != 0) begin
          blank_row(cursor_r);
          cursor_c = 0;
        end
      end
      default: begin
        cell_word = shadow_cells[cell_index(int'(c.cell_row), int'(c.cell_col))];
        r.read_char = cell_word[7:0];
        r.read_attr = cell_word[15:8];
      end
    endcase
    r.cursor_row = cursor_r[4:0];
    r.cursor_col = cursor_c[7:0];
    return r;
  endfunction

  task automatic compare_field(string tag, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued commands, outside the steady run idling at random between transfers
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (n_accepted == n_issued) begin
      if (cmd_backlog.size() > 0 && (steady_run || $urandom_range(99) >= 26) &&
          !(cmd_backlog[0].drain && pending_replies.size() > 0)) begin
        next_slot = cmd_backlog.pop_front();
        cmd_bus <= next_slot.cmd;
        start   <= 1'b1;
        n_issued++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: result check, register tracking, prediction on each transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      cursor_r = 0;
      cursor_c = 0;
      shadow_cfg.fore_color    = 4'd15;
      shadow_cfg.back_color    = 4'd0;
      shadow_cfg.screen_width  = 8'd80;
      shadow_cfg.screen_height = 6'd25;
      shadow_cfg.first_col     = 7'd0;
      shadow_cfg.first_row     = 5'd0;
      pending_replies.delete();
    end else begin
      if (done) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: result with none expected, got row %0d col %0d char %0d attr %0d",
                   $time, rsp.cursor_row, rsp.cursor_col, rsp.read_char, rsp.read_attr);
          mismatches++;
        end else begin
          rsp_t want;
          want = pending_replies.pop_front();
          compare_field("cursor_row", {3'd0, want.cursor_row}, {3'd0, rsp.cursor_row});
          compare_field("cursor_col", want.cursor_col, rsp.cursor_col);
          compare_field("read_char", want.read_char, rsp.read_char);
          compare_field("read_attr", want.read_attr, rsp.read_attr);
          n_compared++;
        end
      end
      if (cfg_we) begin
        n_cfg_writes++;
        case (cfg_idx_t'(cfg_index))
          CFG_FORE_COLOR:    shadow_cfg.fore_color    = cfg_data[3:0];
          CFG_BACK_COLOR:    shadow_cfg.back_color    = cfg_data[3:0];
          CFG_SCREEN_WIDTH:  shadow_cfg.screen_width  = cfg_data[7:0];
          CFG_SCREEN_HEIGHT: shadow_cfg.screen_height = cfg_data[5:0];
          CFG_FIRST_COL:     shadow_cfg.first_col     = cfg_data[6:0];
          CFG_FIRST_ROW:     shadow_cfg.first_row     = cfg_data[4:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        pending_replies.push_back(console_step(cmd_bus));
        kind_count[cmd_bus.kind]++;
        n_accepted++;
      end
    end
  end

  // Watchdog: ends the run after too long with no transfer either way
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("text_console_writer_core verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(kind_t k, logic [7:0] ch, logic [4:0] row, logic [6:0] col,
                           bit drain);
    cmd_slot_t s;
    s.cmd.kind      = k;
    s.cmd.char_code = ch;
    s.cmd.cell_row  = row;
    s.cmd.cell_col  = col;
    s.drain         = drain;
    cmd_backlog.push_back(s);
  endtask

  // Wait until every queued command is through, then let the engine settle
  task automatic wait_idle();
    while (cmd_backlog.size() != 0 || n_accepted != n_issued || pending_replies.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(logic [7:0] fore, logic [7:0] back, logic [7:0] w,
                            logic [7:0] h, logic [7:0] fc, logic [7:0] fr);
    wait_idle();
    write_reg(CFG_FORE_COLOR, fore);
    write_reg(CFG_BACK_COLOR, back);
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
    write_reg(CFG_FIRST_COL, fc);
    write_reg(CFG_FIRST_ROW, fr);
  endtask

  // Random register set; roomy phases use the large geometry, others stay small
  task automatic random_config(bit roomy);
    int w;
    int h;
    int fc;
    int fr;
    int pick;
    if (roomy) begin
      w = $urandom_range(255, 100);
      h = $urandom_range(63, 20);
    end else begin
      pick = $urandom_range(9);
      w = (pick == 0) ? 0 : (pick == 1) ? 1 : $urandom_range(16, 1);
      pick = $urandom_range(9);
      h = (pick == 0) ? 0 : (pick == 1) ? 1 : $urandom_range(8, 1);
    end
    pick = $urandom_range(9);
    fc = (pick < 4) ? 0 : (pick < 8) ? $urandom_range(w) : $urandom_range(255);
    pick = $urandom_range(9);
    fr = (pick < 4) ? 0 : (pick < 8) ? $urandom_range(h) : $urandom_range(255);
    set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'(w), 8'(h),
               8'(fc), 8'(fr));
  endtask

  // Mix of text, newlines, clears, line resets and reads; the odd one drains
  task automatic random_cmds(int count);
    int         pick;
    bit         drain;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
    for (int i = 0; i < count; i++) begin
      pick  = $urandom_range(99);
      drain = ($urandom_range(49) == 0);
      ch    = 8'($urandom_range(255));
      row   = 5'($urandom_range(31));
      col   = 7'($urandom_range(127));
      if (pick < 45)
        queue_cmd(KIND_PUT, ch, row, col, drain);
      else if (pick < 60)
        queue_cmd(KIND_PUT, CODE_NEWLINE, row, col, drain);
      else if (pick < 67)
        queue_cmd(KIND_CLEAR, ch, row, col, drain);
      else if (pick < 77)
        queue_cmd(KIND_LINE, ch, row, col, drain);
      else
        queue_cmd(KIND_READ, ch, row, col, drain);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int k = 0; k < 4; k++) kind_count[k] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Full store, extreme colors; the first clear writes every cell
    set_config(8'h00, 8'hFF, 8'd128, 8'd32, 8'd0, 8'd0);
    queue_cmd(KIND_CLEAR, 8'h00, 5'd0, 7'd0, 1'b0);
    queue_cmd(KIND_READ, 8'h00, 5'd0, 7'd0, 1'b0);
    queue_cmd(KIND_READ, 8'hFF, 5'd31, 7'd127, 1'b0);
    queue_cmd(KIND_PUT, 8'h00, 5'd0, 7'd0, 1'b0);
    queue_cmd(KIND_PUT, 8'hFF, 5'd31, 7'd127, 1'b0);
    queue_cmd(KIND_PUT, 8'h41, 5'd0, 7'd0, 1'b0);
    queue_cmd(KIND_READ, 8'h00, 5'd0, 7'd1, 1'b0);
    queue_cmd(KIND_LINE, 8'h00, 5'd0, 7'd0, 1'b0);
    queue_cmd(KIND_LINE, 8'h00, 5'd0, 7'd0, 1'b0);
    queue_cmd(KIND_PUT, CODE_NEWLINE, 5'd0, 7'd0, 1'b0);
    queue_cmd(KIND_READ, 8'h00, 5'd0, 7'd1, 1'b0);

    // One cell screen: cursor left below the last row, wrap forces scrolls
    set_config(8'h0F, 8'h00, 8'd1, 8'd1, 8'd0, 8'd0);
    queue_cmd(KIND_PUT, CODE_NEWLINE, 5'd0, 7'd0, 1'b0);
    queue_cmd(KIND_PUT, 8'h78, 5'd0, 7'd0, 1'b0);
    queue_cmd(KIND_PUT, 8'h79, 5'd0, 7'd0, 1'b0);
    queue_cmd(KIND_READ, 8'h00, 5'd1, 7'd0, 1'b0);

    // Zero sizes act as one; blanking regions start past the screen
    set_config(8'hA5, 8'h3C, 8'd0, 8'd0, 8'd9, 8'd2);
    queue_cmd(KIND_CLEAR, 8'h00, 5'd0, 7'd0, 1'b0);
    queue_cmd(KIND_PUT, 8'h7A, 5'd0, 7'd0, 1'b0);
    queue_cmd(KIND_LINE, 8'h00, 5'd0, 7'd0, 1'b0);
    queue_cmd(KIND_READ, 8'h00, 5'd31, 7'd127, 1'b0);

    // Oversized geometry clamps to the store; last row and column only
    set_config(8'hFF, 8'hFF, 8'd255, 8'd63, 8'd127, 8'd31);
    queue_cmd(KIND_PUT, 8'h71, 5'd0, 7'd0, 1'b0);
    queue_cmd(KIND_PUT, CODE_NEWLINE, 5'd0, 7'd0, 1'b0);
    queue_cmd(KIND_CLEAR, 8'h00, 5'd0, 7'd0, 1'b0);
    queue_cmd(KIND_READ, 8'h00, 5'd31, 7'd127, 1'b0);
    queue_cmd(KIND_READ, 8'h00, 5'd1, 7'd1, 1'b0);

    // Random phases, mostly small screens, two with large geometry
    for (int phase = 0; phase < 12; phase++) begin
      random_config(phase == 3 || phase == 8);
      steady_run = (phase == 5);
      random_cmds((phase == 3 || phase == 8) ? 40 : 115);
    end

    wait_idle();
    repeat (20) @(negedge clk);
    steady_run = 1'b0;
    $display("covered %0d commands: %0d puts, %0d clears, %0d line resets, %0d reads",
             n_accepted, kind_count[KIND_PUT], kind_count[KIND_CLEAR],
             kind_count[KIND_LINE], kind_count[KIND_READ]);
    $display("%0d scrolls, %0d results compared, %0d register writes",
             scroll_count, n_compared, n_cfg_writes);
    if (mismatches == 0) begin
      $display("text_console_writer_core verification clean");
    end else begin
      $display("text_console_writer_core verification failed");
    end
    $finish;
  end

endmodule
